// ===== src/sbt_pkg.sv =====
// Shared widths, codes and types for the sorted bid table.
`default_nettype none
package sbt_pkg;

  localparam int CUST_W          = 30;
  localparam int PRICE_W         = 31;
  localparam int RIDX_W          = 6;
  localparam int POS_W           = 6;
  localparam int COUNT_W         = 7;
  localparam int DEF_TABLE_DEPTH = 64;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam logic CFG_MIN_PRICE = 1'b0;
  localparam logic CFG_MAX_PRICE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic [CUST_W-1:0]  cust;
    logic [PRICE_W-1:0] price;
  } bid_entry_t;

endpackage
`default_nettype wire

// ===== src/sbt_if.sv =====
// Request, result and configuration channel interfaces of the bid table.
`default_nettype none
interface sbt_in_if;
  import sbt_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [CUST_W-1:0]  customer_id;
  logic [PRICE_W-1:0] bid_price;
  logic [RIDX_W-1:0]  read_index;

  modport source (output valid, opcode, customer_id, bid_price, read_index, input ready);
  modport sink   (input valid, opcode, customer_id, bid_price, read_index, output ready);
endinterface

interface sbt_out_if;
  import sbt_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] entry_count;
  logic [CUST_W-1:0]  entry_customer;
  logic [PRICE_W-1:0] entry_price;

  modport source (output valid, status, position, entry_count, entry_customer, entry_price,
                  input ready);
  modport sink   (input valid, status, position, entry_count, entry_customer, entry_price,
                  output ready);
endinterface

interface sbt_cfg_if;
  import sbt_pkg::*;
  logic               valid;
  logic               ready;
  logic               index;
  logic [PRICE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/sorted_bid_table_insert_top.sv =====
// Sorted bid table: top level with search/shift sequencer and table memory.
// Flow: a read or a rejected insert goes from S_IDLE straight to S_DONE; an
//   accepted insert runs S_SRCH/S_SCMP binary search probes, then S_SHIFT
//   moves the entries above the insert position up, then S_PLACE and S_DONE.
// Throughput: one request at a time; in_req.ready is low from acceptance until
//   the result is in the output register. One memory port pair sets the pace.
// Reset (synchronous, active low): clears bid count and result valid; price
//   bounds go to full range. Table contents kept; nothing beyond the count is read.
`default_nettype none
module sorted_bid_table_insert_top #(
  parameter int TABLE_DEPTH = sbt_pkg::DEF_TABLE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  sbt_in_if.sink     in_req,
  sbt_out_if.source  out_res,
  sbt_cfg_if.sink    cfg_wr
);
  import sbt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,   // issue probe read at mid
    S_SCMP,   // compare probe against new price
    S_SHIFT,  // move entries up, read ahead of write
    S_PLACE,  // write the new bid
    S_DONE    // load output register
  } state_t;

  // ---- configuration ----
  logic [PRICE_W-1:0] min_price_r, max_price_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_price_r <= '0;
      max_price_r <= '1;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        CFG_MIN_PRICE: min_price_r <= cfg_wr.data;
        CFG_MAX_PRICE: max_price_r <= cfg_wr.data;
        default:       ;
      endcase
    end
  end

  // ---- table memory: one write, one registered read ----
  bid_entry_t        mem [TABLE_DEPTH];
  bid_entry_t        rdata_r;
  logic              mem_re, mem_we;
  logic [AW-1:0]     raddr, waddr;
  bid_entry_t        wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // ---- sequencer state ----
  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      lo_r, hi_r;       // search bounds; lo_r ends as insert position
  logic [AW-1:0]      k_r, wk_r;        // shift read cursor, pending write target
  logic               pend_r;           // rdata_r holds an entry still to be written
  logic               op_r;
  logic [CUST_W-1:0]  cust_r;
  logic [PRICE_W-1:0] price_r;
  status_t            st_r;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CUST_W-1:0]  out_cust_r;
  logic [PRICE_W-1:0] out_price_r;

  logic               in_acc;
  logic               price_bad, table_full, idx_ok;
  logic [AW-1:0]      mid;
  logic [31:0]        ridx32, pos32, cnt32;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;

  assign price_bad  = (in_req.bid_price < min_price_r) || (in_req.bid_price > max_price_r);
  assign table_full = (count_r == CW'(TABLE_DEPTH));
  assign ridx32     = 32'(in_req.read_index);
  assign idx_ok     = (ridx32 < 32'(count_r));
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign pos32      = 32'(lo_r);
  assign cnt32      = 32'(count_r);

  // memory port steering
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = mid;
    waddr  = wk_r;
    wdata  = rdata_r;
    unique case (state_r)
      S_IDLE: begin
        mem_re = in_acc && (in_req.opcode == OP_READ) && idx_ok;
        raddr  = ridx32[AW-1:0];
      end
      S_SRCH: begin
        mem_re = (lo_r < hi_r);
        raddr  = mid;
      end
      S_SHIFT: begin
        mem_we = pend_r;
        mem_re = (k_r > lo_r);
        raddr  = k_r - AW'(1);
      end
      S_PLACE: begin
        mem_we = 1'b1;
        waddr  = lo_r;
        wdata  = '{cust: cust_r, price: price_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the load below decides valid on its own
      if (out_res.valid && out_res.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_req.opcode;
            cust_r  <= in_req.customer_id;
            price_r <= in_req.bid_price;
            lo_r    <= '0;
            hi_r    <= count_r[AW-1:0];
            if (in_req.opcode == OP_INSERT) begin
              if (price_bad) begin
                st_r    <= ST_RANGE;
                state_r <= S_DONE;
              end else if (table_full) begin
                st_r    <= ST_FULL;
                state_r <= S_DONE;
              end else begin
                st_r    <= ST_OK;
                state_r <= S_SRCH;
              end
            end else begin
              st_r    <= idx_ok ? ST_OK : ST_INDEX;
              state_r <= S_DONE;
            end
          end
        end
        S_SRCH: begin
          if (lo_r < hi_r) begin
            state_r <= S_SCMP;
          end else begin
            k_r     <= count_r[AW-1:0];
            pend_r  <= 1'b0;
            state_r <= S_SHIFT;
          end
        end
        S_SCMP: begin
          if (rdata_r.price < price_r) lo_r <= mid + AW'(1);
          else                         hi_r <= mid;
          state_r <= S_SRCH;
        end
        S_SHIFT: begin
          if (k_r > lo_r) begin
            wk_r   <= k_r;
            k_r    <= k_r - AW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r  <= 1'b0;
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          count_r <= count_r + CW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_count_r  <= cnt32[COUNT_W-1:0];
            out_pos_r    <= (op_r == OP_INSERT && st_r == ST_OK) ? pos32[POS_W-1:0] : '0;
            out_cust_r   <= (op_r == OP_READ && st_r == ST_OK) ? rdata_r.cust : '0;
            out_price_r  <= (op_r == OP_READ && st_r == ST_OK) ? rdata_r.price : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_status_r;
  assign out_res.position       = out_pos_r;
  assign out_res.entry_count    = out_count_r;
  assign out_res.entry_customer = out_cust_r;
  assign out_res.entry_price    = out_price_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH)
    else $error("bid count beyond table depth");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_SCMP) |-> (lo_r <= hi_r))
    else $error("search bounds crossed");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(waddr) <= 32'(count_r)))
    else $error("table write beyond held entries");

  a_place_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not bump count");

endmodule
`default_nettype wire

// ===== bench/tb_sorted_bid_table_insert_top.sv =====
// Self-checking testbench for the sorted bid table: directed plan, then random phases.
`timescale 1ns / 1ps
module tb_sorted_bid_table_insert_top;
  import sbt_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam int CUST_TOP = 999999999;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQUESTS = 75;

  // one request as it goes onto the input channel
  typedef struct packed {
    logic               op;
    logic [CUST_W-1:0]  cust;
    logic [PRICE_W-1:0] price;
    logic [RIDX_W-1:0]  ridx;
  } bid_req_t;

  // one result as it should come off the output channel
  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic [CUST_W-1:0]  entry_customer;
    logic [PRICE_W-1:0] entry_price;
  } bid_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // directed plan row: a request (outcome typed in or left to the predictor)
  // or a bound register write
  typedef struct {
    row_kind_t          kind;
    bid_req_t           req;
    logic               typed;
    bid_result_t        res;
    logic               cfg_idx;
    logic [PRICE_W-1:0] cfg_data;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sbt_in_if  in_req ();
  sbt_out_if out_res ();
  sbt_cfg_if cfg_wr ();

  sorted_bid_table_insert_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the table, the count and the price bounds.
  // ---------------------------------------------------------------------------
  logic [PRICE_W-1:0] price_tab [TABLE_DEPTH];
  logic [CUST_W-1:0]  cust_tab  [TABLE_DEPTH];
  logic [COUNT_W-1:0] bid_count;
  logic [PRICE_W-1:0] lo_bound;
  logic [PRICE_W-1:0] hi_bound;

  bid_result_t awaited_outcomes [$];
  plan_row_t   plan [$];
  bid_result_t want;
  int          mismatches = 0;
  logic        quiet_spell;

  // Applies one accepted request to the shadow table and returns its outcome.
  // The first held price not below the new one marks the slot, so a new bid
  // lands behind all cheaper bids and ahead of any at the same price.
  function automatic bid_result_t bid_outcome(bid_req_t r);
    bid_result_t res;
    int          slot;
    res = '0;
    res.status = ST_OK;
    if (r.op == OP_INSERT) begin
      // range test first: a bad price on a full table is a range error
      if (r.price < lo_bound || r.price > hi_bound) begin
        res.status = ST_RANGE;
      end else if (bid_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < bid_count && price_tab[slot] < r.price) slot++;
        for (int k = int'(bid_count); k > slot; k--) begin
          price_tab[k] = price_tab[k-1];
          cust_tab[k]  = cust_tab[k-1];
        end
        price_tab[slot] = r.price;
        cust_tab[slot]  = r.cust;
        bid_count       = bid_count + 1'b1;
        res.position    = POS_W'(slot);
      end
    end else if (r.ridx >= bid_count) begin
      res.status = ST_INDEX;
    end else begin
      res.entry_customer = cust_tab[r.ridx];
      res.entry_price    = price_tab[r.ridx];
    end
    res.entry_count = bid_count;
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  // During a quiet spell neither side idles at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_spell || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan rows
  // ---------------------------------------------------------------------------
  function automatic plan_row_t ask(logic op, int cust, logic [PRICE_W-1:0] price, int ridx);
    plan_row_t row;
    row.kind     = ROW_REQ;
    row.req.op   = op;
    row.req.cust = CUST_W'(cust);
    row.req.price = price;
    row.req.ridx = RIDX_W'(ridx);
    row.typed    = 1'b0;
    row.res      = '0;
    row.cfg_idx  = CFG_MIN_PRICE;
    row.cfg_data = '0;
    return row;
  endfunction

  function automatic plan_row_t ask_typed(logic op, int cust, logic [PRICE_W-1:0] price,
                                          int ridx, status_t st, int pos, int cnt,
                                          int ecust, logic [PRICE_W-1:0] eprice);
    plan_row_t row;
    row = ask(op, cust, price, ridx);
    row.typed              = 1'b1;
    row.res.status         = st;
    row.res.position       = POS_W'(pos);
    row.res.entry_count    = COUNT_W'(cnt);
    row.res.entry_customer = CUST_W'(ecust);
    row.res.entry_price    = eprice;
    return row;
  endfunction

  function automatic plan_row_t set_reg(logic idx, logic [PRICE_W-1:0] data);
    plan_row_t row;
    row = ask(OP_READ, 0, '0, 0);
    row.kind     = ROW_CFG;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Random request: prices aimed at the bounds, just outside them, at prices
  // already held (ties) and at a small pool; reads mostly within the count.
  // ---------------------------------------------------------------------------
  function automatic bid_req_t make_random_req();
    bid_req_t r;
    int       pick;
    r.cust  = CUST_W'($urandom_range(CUST_TOP, 0));
    r.price = PRICE_W'($urandom());
    r.ridx  = RIDX_W'($urandom());
    r.op    = ($urandom_range(99) < 45) ? OP_INSERT : OP_READ;
    if (r.op == OP_READ) begin
      if (bid_count != 0 && $urandom_range(99) < 85)
        r.ridx = RIDX_W'($urandom_range(int'(bid_count) - 1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if (lo_bound <= hi_bound) r.price = PRICE_W'($urandom_range(hi_bound, lo_bound));
      end else if (pick < 45) begin
        r.price = lo_bound;
      end else if (pick < 55) begin
        r.price = hi_bound;
      end else if (pick < 62) begin
        r.price = (lo_bound == 0) ? lo_bound : lo_bound - 1'b1;
      end else if (pick < 69) begin
        r.price = (hi_bound == PRICE_MAX) ? hi_bound : hi_bound + 1'b1;
      end else if (pick < 77) begin
        r.price = PRICE_W'($urandom_range(20));
      end else if (pick < 88) begin
        if (bid_count != 0) r.price = price_tab[$urandom_range(int'(bid_count) - 1)];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel tasks; all are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  // Sender holds off until every outstanding result has been taken.
  task automatic wait_drained();
    in_req.valid = 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
  endtask

  // Valid stays high into the next request when no gap is drawn, so it is
  // never dropped and raised within one step.
  task automatic send_request(bid_req_t r, logic typed, bid_result_t typed_res);
    int          gap;
    bid_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid       = 1'b1;
    in_req.opcode      = r.op;
    in_req.customer_id = r.cust;
    in_req.bid_price   = r.price;
    in_req.read_index  = r.ridx;
    do @(posedge clk); while (!in_req.ready);
    // accepted: the predictor runs even where the outcome is typed in,
    // so the shadow table keeps in step
    pred = bid_outcome(r);
    awaited_outcomes.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // Bound registers are only touched once the table has gone quiet.
  task automatic cfg_write(logic idx, logic [PRICE_W-1:0] data);
    wait_drained();
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data  = data;
    do @(posedge clk); while (!cfg_wr.ready);
    if (idx == CFG_MIN_PRICE) lo_bound = data;
    else hi_bound = data;
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: every taken result is matched against the oldest outcome.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_res.status);
        mismatches++;
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("status", 32'(want.status), 32'(out_res.status));
        check_field("position", 32'(want.position), 32'(out_res.position));
        check_field("entry_count", 32'(want.entry_count), 32'(out_res.entry_count));
        check_field("entry_customer", 32'(want.entry_customer),
                    32'(out_res.entry_customer));
        check_field("entry_price", 32'(want.entry_price), 32'(out_res.entry_price));
      end
    end
  end

  // Receiver back-pressure: ready mostly high, dropped for drawn stretches.
  initial begin
    int hold;
    hold = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_res.ready = 1'b0;
        hold--;
      end else begin
        out_res.ready = 1'b1;
        if ($urandom_range(3) == 0) hold = pick_gap();
      end
    end
  end

  // Quiet spells: now and then both sides run flat out for a while.
  initial begin
    quiet_spell = 1'b0;
    forever begin
      repeat ($urandom_range(900, 150)) @(posedge clk);
      quiet_spell = ($urandom_range(3) == 0);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [PRICE_W-1:0] new_lo;
    logic [PRICE_W-1:0] new_hi;
    logic [PRICE_W-1:0] a;
    logic [PRICE_W-1:0] b;

    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.opcode      = OP_INSERT;
    in_req.customer_id = '0;
    in_req.bid_price   = '0;
    in_req.read_index  = '0;
    cfg_wr.valid       = 1'b0;
    cfg_wr.index       = CFG_MIN_PRICE;
    cfg_wr.data        = '0;

    bid_count = '0;
    lo_bound  = '0;
    hi_bound  = PRICE_MAX;

    // empty table, extremes, ties, bounds inclusive, crossed bounds
    plan.push_back(ask_typed(OP_READ, 0, '0, 0, ST_INDEX, 0, 0, 0, '0));
    plan.push_back(ask_typed(OP_READ, CUST_TOP, PRICE_MAX, 63, ST_INDEX, 0, 0, 0, '0));
    plan.push_back(ask_typed(OP_INSERT, 0, '0, 63, ST_OK, 0, 1, 0, '0));
    plan.push_back(ask_typed(OP_INSERT, CUST_TOP, PRICE_MAX, 0, ST_OK, 1, 2, 0, '0));
    // same price as a held bid: goes in ahead of it
    plan.push_back(ask_typed(OP_INSERT, 7, '0, 0, ST_OK, 0, 3, 0, '0));
    plan.push_back(ask_typed(OP_READ, 0, '0, 0, ST_OK, 0, 3, 7, '0));
    plan.push_back(ask_typed(OP_READ, 0, '0, 1, ST_OK, 0, 3, 0, '0));
    plan.push_back(ask_typed(OP_READ, 0, '0, 2, ST_OK, 0, 3, CUST_TOP, PRICE_MAX));
    plan.push_back(ask_typed(OP_READ, 0, '0, 3, ST_INDEX, 0, 3, 0, '0));
    plan.push_back(ask(OP_INSERT, 1, 1000, 0));
    plan.push_back(set_reg(CFG_MIN_PRICE, 100));
    plan.push_back(set_reg(CFG_MAX_PRICE, 200));
    plan.push_back(ask_typed(OP_INSERT, 5, 99, 0, ST_RANGE, 0, 4, 0, '0));
    plan.push_back(ask_typed(OP_INSERT, 5, 201, 0, ST_RANGE, 0, 4, 0, '0));
    plan.push_back(ask(OP_INSERT, 11, 100, 0));
    plan.push_back(ask(OP_INSERT, 12, 200, 0));
    plan.push_back(ask(OP_READ, 0, '0, 2));
    // minimum above maximum: nothing gets in
    plan.push_back(set_reg(CFG_MIN_PRICE, 300));
    plan.push_back(ask_typed(OP_INSERT, 13, 250, 0, ST_RANGE, 0, 6, 0, '0));
    plan.push_back(set_reg(CFG_MIN_PRICE, '0));
    plan.push_back(set_reg(CFG_MAX_PRICE, PRICE_MAX));
    plan.push_back(ask(OP_INSERT, 3, PRICE_MAX, 0));
    plan.push_back(ask(OP_READ, 0, '0, 6));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) cfg_write(plan[i].cfg_idx, plan[i].cfg_data);
      else send_request(plan[i].req, plan[i].typed, plan[i].res);
    end

    // Random phases, each under its own bound setting. The table only grows,
    // so early phases fill it and later ones run against a full table.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      a = PRICE_W'($urandom());
      b = PRICE_W'($urandom());
      case (ph % 8)
        0: begin new_lo = '0; new_hi = PRICE_MAX; end
        1: begin new_lo = PRICE_W'($urandom_range(15)); new_hi = new_lo; end
        2: begin
          new_hi = PRICE_W'($urandom_range(PRICE_MAX - 1));
          new_lo = PRICE_W'($urandom_range(PRICE_MAX, new_hi + 1));
        end
        3: begin new_lo = (a < b) ? a : b; new_hi = (a < b) ? b : a; end
        4: begin new_lo = '0; new_hi = '0; end
        5: begin new_lo = PRICE_MAX; new_hi = PRICE_MAX; end
        6: begin
          new_lo = PRICE_W'($urandom_range(1000));
          new_hi = PRICE_W'($urandom_range(PRICE_MAX, new_lo));
        end
        default: begin new_lo = a; new_hi = PRICE_MAX; end
      endcase
      cfg_write(CFG_MIN_PRICE, new_lo);
      cfg_write(CFG_MAX_PRICE, new_hi);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(199) == 0) wait_drained();
        send_request(make_random_req(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
